// ===== design/task_to_host_layout_assert.svh =====
// Assertion macros for the task-to-host layout block.
// Used by the top level; no other dependencies.
`ifndef TASK_TO_HOST_LAYOUT_ASSERT_SVH
`define TASK_TO_HOST_LAYOUT_ASSERT_SVH
`ifndef SYNTH
`define TTL_ASSERT(lbl, ck, rst_n, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define TTL_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define TTL_ASSERT(lbl, ck, rst_n, prop)
`define TTL_ASSERT_NEXT(lbl, ck, rst_n, ante, cons)
`endif
`endif

// ===== design/ttl_pkg.sv =====
// Shared constants, codes and control structs of the task layout block.
// No dependencies.
package ttl_pkg;

	localparam int MAX_HOSTS_DEF = 64;
	localparam int MAX_TASKS_DEF = 1024;

	localparam int FUNC_W   = 2;
	localparam int CPUS_W   = 10;
	localparam int REP_W    = 7;
	localparam int TIDX_W   = 10;
	localparam int HSEL_W   = 6;
	localparam int HOT_W    = 6;
	localparam int RANK_W   = 10;
	localparam int CNT_W    = 11;
	localparam int TT_W     = 11;
	localparam int HT_W     = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_LOAD  = 2'd0,
		FUNC_QTASK = 2'd1,
		FUNC_QHOST = 2'd2
	} ttl_func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TASK_TOTAL = 2'd0,
		CFG_HOST_TOTAL = 2'd1,
		CFG_DIST_MODE  = 2'd2
	} ttl_cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_LINIT,
		ST_WRD,
		ST_WWR,
		ST_BRD,
		ST_BCHK,
		ST_BWR,
		ST_QRD,
		ST_QWT,
		ST_RESP
	} ttl_state_t;

	typedef struct packed {
		logic rd;
		logic cpu_we;
		logic cnt_we;
		logic clear;
	} hm_ctl_t;

	typedef struct packed {
		logic rd;
		logic we;
	} tm_ctl_t;

	typedef struct packed {
		logic layout_done;
		logic resp_wait;
	} ttl_stat_t;

endpackage

// ===== design/ttl_in_if.sv =====
// Request channel: load and query items.
// Depends on ttl_pkg.
interface ttl_in_if;
	import ttl_pkg::*;
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [CPUS_W-1:0]   group_cpus;
	logic [REP_W-1:0]    group_repeat;
	logic [TIDX_W-1:0]   task_index;
	logic [HSEL_W-1:0]   host_select;

	modport source (output valid, func, group_cpus, group_repeat, task_index, host_select,
		input ready);
	modport sink (input valid, func, group_cpus, group_repeat, task_index, host_select,
		output ready);
endinterface

// ===== design/ttl_out_if.sv =====
// Response channel: one result per request.
// Depends on ttl_pkg.
interface ttl_out_if;
	import ttl_pkg::*;
	logic               valid;
	logic               ready;
	logic               status;
	logic [HOT_W-1:0]   host_of_task;
	logic [RANK_W-1:0]  rank_on_host;
	logic [CNT_W-1:0]   host_task_count;
	logic [CPUS_W-1:0]  host_cpu_count;

	modport source (output valid, status, host_of_task, rank_on_host, host_task_count,
		host_cpu_count, input ready);
	modport sink (input valid, status, host_of_task, rank_on_host, host_task_count,
		host_cpu_count, output ready);
endinterface

// ===== design/ttl_cfg_if.sv =====
// Register write channel.
// Depends on ttl_pkg.
interface ttl_cfg_if;
	import ttl_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== design/ttl_host_mem.sv =====
// Per-host store: cpu count and placed-task count, registered read.
// Depends on ttl_pkg; task counts carry valid bits cleared per layout.
module ttl_host_mem #(
	parameter int MAX_HOSTS = ttl_pkg::MAX_HOSTS_DEF,
	parameter int MAX_TASKS = ttl_pkg::MAX_TASKS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ttl_pkg::hm_ctl_t                   ctl,
	input  logic [$clog2(MAX_HOSTS)-1:0]       rd_addr,
	input  logic [$clog2(MAX_HOSTS)-1:0]       wr_addr,
	input  logic [ttl_pkg::CPUS_W-1:0]         cpu_wdata,
	input  logic [$clog2(MAX_TASKS+1)-1:0]     cnt_wdata,
	output logic [ttl_pkg::CPUS_W-1:0]         cpu_rdata,
	output logic [$clog2(MAX_TASKS+1)-1:0]     cnt_rdata
);
	import ttl_pkg::*;
	localparam int TCW = $clog2(MAX_TASKS + 1);

	logic [CPUS_W-1:0]    cpus_mem [MAX_HOSTS];
	logic [TCW-1:0]       cnt_mem  [MAX_HOSTS];
	logic [MAX_HOSTS-1:0] valid_q;
	logic [CPUS_W-1:0]    cpu_rd_q;
	logic [TCW-1:0]       cnt_rd_q;
	logic                 vld_rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.clear) begin
			valid_q <= '0;
		end else if (ctl.cnt_we) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cpu_we)
			cpus_mem[wr_addr] <= cpu_wdata;
		if (ctl.cnt_we)
			cnt_mem[wr_addr] <= cnt_wdata;
		if (ctl.rd) begin
			cpu_rd_q <= cpus_mem[rd_addr];
			cnt_rd_q <= cnt_mem[rd_addr];
			vld_rd_q <= valid_q[rd_addr];
		end
	end

	assign cpu_rdata = cpu_rd_q;
	assign cnt_rdata = vld_rd_q ? cnt_rd_q : '0;
endmodule

// ===== design/ttl_task_mem.sv =====
// Per-task store: host index and rank on host, registered read.
// Depends on ttl_pkg.
module ttl_task_mem #(
	parameter int MAX_HOSTS = ttl_pkg::MAX_HOSTS_DEF,
	parameter int MAX_TASKS = ttl_pkg::MAX_TASKS_DEF
) (
	input  logic                          clk,
	input  ttl_pkg::tm_ctl_t              ctl,
	input  logic [$clog2(MAX_TASKS)-1:0]  rd_addr,
	input  logic [$clog2(MAX_TASKS)-1:0]  wr_addr,
	input  logic [$clog2(MAX_HOSTS)-1:0]  host_wdata,
	input  logic [$clog2(MAX_TASKS)-1:0]  rank_wdata,
	output logic [$clog2(MAX_HOSTS)-1:0]  host_rdata,
	output logic [$clog2(MAX_TASKS)-1:0]  rank_rdata
);
	import ttl_pkg::*;
	localparam int HW = $clog2(MAX_HOSTS);
	localparam int TW = $clog2(MAX_TASKS);

	logic [HW-1:0] host_mem [MAX_TASKS];
	logic [TW-1:0] rank_mem [MAX_TASKS];

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			host_mem[wr_addr] <= host_wdata;
			rank_mem[wr_addr] <= rank_wdata;
		end
		if (ctl.rd) begin
			host_rdata <= host_mem[rd_addr];
			rank_rdata <= rank_mem[rd_addr];
		end
	end
endmodule

// ===== design/ttl_ctrl.sv =====
// Sequencer: host loads, layout walk over rounds, block numbering pass, queries.
// Depends on ttl_pkg and the channel interfaces; drives both stores.
module ttl_ctrl #(
	parameter int MAX_HOSTS = ttl_pkg::MAX_HOSTS_DEF,
	parameter int MAX_TASKS = ttl_pkg::MAX_TASKS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	ttl_in_if.sink                            req,
	ttl_out_if.source                         rsp,
	input  logic [ttl_pkg::TT_W-1:0]          task_total,
	input  logic [ttl_pkg::HT_W-1:0]          host_total,
	input  logic                              dist_mode,
	output ttl_pkg::hm_ctl_t                  hm_ctl,
	output logic [$clog2(MAX_HOSTS)-1:0]      hm_rd_addr,
	output logic [$clog2(MAX_HOSTS)-1:0]      hm_wr_addr,
	output logic [ttl_pkg::CPUS_W-1:0]        hm_cpu_wdata,
	output logic [$clog2(MAX_TASKS+1)-1:0]    hm_cnt_wdata,
	input  logic [ttl_pkg::CPUS_W-1:0]        hm_cpu_rdata,
	input  logic [$clog2(MAX_TASKS+1)-1:0]    hm_cnt_rdata,
	output ttl_pkg::tm_ctl_t                  tm_ctl,
	output logic [$clog2(MAX_TASKS)-1:0]      tm_rd_addr,
	output logic [$clog2(MAX_TASKS)-1:0]      tm_wr_addr,
	output logic [$clog2(MAX_HOSTS)-1:0]      tm_host_wdata,
	output logic [$clog2(MAX_TASKS)-1:0]      tm_rank_wdata,
	input  logic [$clog2(MAX_HOSTS)-1:0]      tm_host_rdata,
	input  logic [$clog2(MAX_TASKS)-1:0]      tm_rank_rdata,
	output ttl_pkg::ttl_stat_t                stat
);
	import ttl_pkg::*;
	localparam int HW   = $clog2(MAX_HOSTS);
	localparam int TW   = $clog2(MAX_TASKS);
	localparam int HCW  = $clog2(MAX_HOSTS + 1);
	localparam int TCW  = $clog2(MAX_TASKS + 1);
	localparam int RW   = TCW + 1;
	localparam int CW_A = (TCW > HCW) ? TCW : HCW;
	localparam int CW   = (CW_A > TT_W) ? CW_A : TT_W;
	localparam int RCW  = ((RW > CPUS_W) ? RW : CPUS_W) + 1;

	ttl_state_t state_q, state_d;

	// control state
	logic           layout_done_q;
	logic [HCW-1:0] hosts_loaded_q;
	logic [TCW-1:0] laid_tasks_q;
	logic [HCW-1:0] laid_hosts_q;
	logic           rsp_valid_q;

	// item and walk registers
	logic [FUNC_W-1:0] func_q;
	logic [CPUS_W-1:0] cpus_q;
	logic [REP_W-1:0]  rep_left_q;
	logic [TIDX_W-1:0] tidx_q;
	logic [HSEL_W-1:0] hsel_q;
	logic [RW-1:0]     round_q;
	logic [TCW-1:0]    placed_q;
	logic [HW-1:0]     h_q;
	logic              over_q;
	logic              spare_q;
	logic              cyc_q;
	logic [TCW-1:0]    id_q;
	logic [TCW-1:0]    k_q;
	logic [TCW-1:0]    cnt_q;
	logic              res_status_q;
	logic [HOT_W-1:0]  res_host_q;
	logic [RANK_W-1:0] res_rank_q;
	logic [CNT_W-1:0]  res_cnt_q;
	logic [CPUS_W-1:0] res_cpu_q;

	logic          acc, slot_free, hl_full, take, more, spare_nx, walk_end, last_h;
	logic          t_ok, s_ok, is_qtask, is_qhost;
	logic [CW-1:0] nt_c, nh_a, nh_c;
	logic [TCW-1:0] placed_nx;

	assign acc       = req.valid && req.ready;
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign hl_full   = (hosts_loaded_q == HCW'(MAX_HOSTS));

	// clamped counts for the layout
	assign nt_c = (CW'(task_total) < CW'(MAX_TASKS)) ? CW'(task_total) : CW'(MAX_TASKS);
	assign nh_a = (CW'(host_total) < nt_c) ? CW'(host_total) : nt_c;
	assign nh_c = (nh_a < CW'(MAX_HOSTS)) ? nh_a : CW'(MAX_HOSTS);

	assign take      = (RCW'(round_q) < RCW'(hm_cpu_rdata)) || over_q;
	assign more      = (RCW'(round_q) + RCW'(1) < RCW'(hm_cpu_rdata));
	assign spare_nx  = spare_q || (take && more);
	assign placed_nx = placed_q + TCW'(take);
	assign walk_end  = (placed_nx == laid_tasks_q);
	assign last_h    = (HCW'(h_q) + HCW'(1) == laid_hosts_q);

	assign is_qtask = (func_q == FUNC_QTASK);
	assign is_qhost = (func_q == FUNC_QHOST);
	assign t_ok     = (CW'(tidx_q) < CW'(laid_tasks_q));
	assign s_ok     = (CW'(hsel_q) < CW'(laid_hosts_q));

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign stat.layout_done = layout_done_q;
	assign stat.resp_wait   = (state_q == ST_RESP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d       = state_q;
		hm_ctl        = '0;
		tm_ctl        = '0;
		hm_rd_addr    = h_q;
		hm_wr_addr    = h_q;
		hm_cpu_wdata  = cpus_q;
		hm_cnt_wdata  = hm_cnt_rdata + TCW'(1);
		tm_rd_addr    = TW'(tidx_q);
		tm_wr_addr    = id_q[TW-1:0];
		tm_host_wdata = h_q;
		tm_rank_wdata = TW'(k_q);
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					unique case (ttl_func_t'(req.func))
						FUNC_LOAD:  state_d = ST_LOAD;
						FUNC_QTASK,
						FUNC_QHOST: state_d = layout_done_q ? ST_QRD : ST_LINIT;
						default:    state_d = ST_RESP;
					endcase
				end
			end
			ST_LOAD: begin
				hm_ctl.cpu_we = !hl_full;
				hm_wr_addr    = hosts_loaded_q[HW-1:0];
				if (rep_left_q == REP_W'(1))
					state_d = ST_RESP;
			end
			ST_LINIT: begin
				hm_ctl.clear = 1'b1;
				state_d = (nh_c == '0) ? ST_QRD : ST_WRD;
			end
			ST_WRD: begin
				hm_ctl.rd = 1'b1;
				state_d   = ST_WWR;
			end
			ST_WWR: begin
				hm_ctl.cnt_we = take;
				tm_ctl.we     = take && cyc_q;
				tm_wr_addr    = placed_q[TW-1:0];
				tm_rank_wdata = TW'(hm_cnt_rdata);
				if (walk_end)
					state_d = cyc_q ? ST_QRD : ST_BRD;
				else
					state_d = ST_WRD;
			end
			ST_BRD: begin
				hm_ctl.rd = 1'b1;
				state_d   = ST_BCHK;
			end
			ST_BCHK: begin
				if (hm_cnt_rdata != '0)
					state_d = ST_BWR;
				else
					state_d = last_h ? ST_QRD : ST_BRD;
			end
			ST_BWR: begin
				tm_ctl.we = 1'b1;
				if (k_q + TCW'(1) == cnt_q)
					state_d = last_h ? ST_QRD : ST_BRD;
			end
			ST_QRD: begin
				hm_rd_addr = HW'(hsel_q);
				hm_ctl.rd  = is_qhost && s_ok;
				tm_ctl.rd  = is_qtask && t_ok;
				state_d    = ((is_qhost && s_ok) || (is_qtask && t_ok)) ? ST_QWT : ST_RESP;
			end
			ST_QWT: state_d = ST_RESP;
			ST_RESP: begin
				if (slot_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_done_q  <= 1'b0;
			hosts_loaded_q <= '0;
			laid_tasks_q   <= '0;
			laid_hosts_q   <= '0;
			rsp_valid_q    <= 1'b0;
		end else begin
			// a load after a finished layout starts a fresh host table
			if (acc && req.func == FUNC_LOAD && layout_done_q) begin
				layout_done_q  <= 1'b0;
				hosts_loaded_q <= '0;
			end
			if (state_q == ST_LOAD && !hl_full)
				hosts_loaded_q <= hosts_loaded_q + HCW'(1);
			if (state_q == ST_LINIT) begin
				layout_done_q <= 1'b1;
				laid_hosts_q  <= HCW'(nh_c);
				laid_tasks_q  <= (nh_c == '0) ? '0 : TCW'(nt_c);
			end
			if (state_q == ST_RESP && slot_free)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					func_q       <= req.func;
					cpus_q       <= req.group_cpus;
					rep_left_q   <= (req.group_repeat == '0) ? REP_W'(1) : req.group_repeat;
					tidx_q       <= req.task_index;
					hsel_q       <= req.host_select;
					res_status_q <= !(req.func == FUNC_LOAD || req.func == FUNC_QTASK ||
						req.func == FUNC_QHOST);
					res_host_q   <= '0;
					res_rank_q   <= '0;
					res_cnt_q    <= '0;
					res_cpu_q    <= '0;
				end
			end
			ST_LOAD: begin
				rep_left_q <= rep_left_q - REP_W'(1);
				if (hl_full)
					res_status_q <= 1'b1;
			end
			ST_LINIT: begin
				round_q  <= '0;
				placed_q <= '0;
				h_q      <= '0;
				over_q   <= 1'b0;
				spare_q  <= 1'b0;
				cyc_q    <= dist_mode;
			end
			ST_WWR: begin
				placed_q <= placed_nx;
				if (walk_end) begin
					h_q  <= '0;
					id_q <= '0;
				end else if (last_h) begin
					// round over; no spare cpu left means oversubscribe from now on
					h_q     <= '0;
					round_q <= round_q + RW'(1);
					over_q  <= over_q || !spare_nx;
					spare_q <= 1'b0;
				end else begin
					h_q     <= h_q + HW'(1);
					spare_q <= spare_nx;
				end
			end
			ST_BCHK: begin
				cnt_q <= hm_cnt_rdata;
				k_q   <= '0;
				if (hm_cnt_rdata == '0 && !last_h)
					h_q <= h_q + HW'(1);
			end
			ST_BWR: begin
				id_q <= id_q + TCW'(1);
				k_q  <= k_q + TCW'(1);
				if (k_q + TCW'(1) == cnt_q && !last_h)
					h_q <= h_q + HW'(1);
			end
			ST_QRD: begin
				if (!((is_qhost && s_ok) || (is_qtask && t_ok)))
					res_status_q <= 1'b1;
			end
			ST_QWT: begin
				if (is_qtask) begin
					res_host_q <= HOT_W'(tm_host_rdata);
					res_rank_q <= RANK_W'(tm_rank_rdata);
				end else begin
					res_cnt_q <= CNT_W'(hm_cnt_rdata);
					res_cpu_q <= hm_cpu_rdata;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && slot_free) begin
			rsp.status          <= res_status_q;
			rsp.host_of_task    <= res_host_q;
			rsp.rank_on_host    <= res_rank_q;
			rsp.host_task_count <= res_cnt_q;
			rsp.host_cpu_count  <= res_cpu_q;
		end
	end
endmodule

// ===== design/task_to_host_layout.sv =====
// Task-to-host layout: top level with registers, sequencer and the two stores.
// Depends on ttl_pkg, the channel interfaces, ttl_host_mem, ttl_task_mem, ttl_ctrl.
//
//  channel | role | transfer carries
//  --------+------+---------------------------------------------------------
//  req     | sink | func, group_cpus, group_repeat, task_index, host_select
//  rsp     | src  | status, host_of_task, rank_on_host, host_task_count, cpus
//  cfg     | sink | index, data (task_total, host_total, dist_mode)
//
// One request is worked at a time; the next is taken while a result waits in rsp.
// A load of R hosts makes one host_cpus write per cycle.
// A query with the layout done goes through check, store read, result and output.
// First query after a load adds the layout: a setup step, then a read and a write
// of the host store for each host visit over all rounds; block mode adds a numbering
// pass that reads and checks each host and writes each of its tasks. Async reset clears control only.
`include "task_to_host_layout_assert.svh"

module task_to_host_layout #(
	parameter int MAX_HOSTS = ttl_pkg::MAX_HOSTS_DEF,
	parameter int MAX_TASKS = ttl_pkg::MAX_TASKS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ttl_in_if.sink    req,
	ttl_out_if.source rsp,
	ttl_cfg_if.sink   cfg
);
	import ttl_pkg::*;
	localparam int HW  = $clog2(MAX_HOSTS);
	localparam int TW  = $clog2(MAX_TASKS);
	localparam int TCW = $clog2(MAX_TASKS + 1);

	logic [TT_W-1:0] task_total_q;
	logic [HT_W-1:0] host_total_q;
	logic            dist_mode_q;

	hm_ctl_t         hm_ctl;
	logic [HW-1:0]   hm_rd_addr, hm_wr_addr;
	logic [CPUS_W-1:0] hm_cpu_wdata, hm_cpu_rdata;
	logic [TCW-1:0]  hm_cnt_wdata, hm_cnt_rdata;
	tm_ctl_t         tm_ctl;
	logic [TW-1:0]   tm_rd_addr, tm_wr_addr, tm_rank_wdata, tm_rank_rdata;
	logic [HW-1:0]   tm_host_wdata, tm_host_rdata;
	ttl_stat_t       stat;
	logic            load_xfer;

	// registers take a write at any time; unknown indexes are dropped
	assign cfg.ready = 1'b1;

	// load transfer on the request channel
	assign load_xfer = req.valid && req.ready && (req.func == FUNC_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_total_q <= TT_W'(1);
			host_total_q <= HT_W'(1);
			dist_mode_q  <= 1'b0;
		end else if (cfg.valid) begin
			unique case (ttl_cfg_idx_t'(cfg.index))
				CFG_TASK_TOTAL: task_total_q <= cfg.data[TT_W-1:0];
				CFG_HOST_TOTAL: host_total_q <= cfg.data[HT_W-1:0];
				CFG_DIST_MODE:  dist_mode_q  <= cfg.data[0];
				default: ;
			endcase
		end
	end

	ttl_ctrl #(.MAX_HOSTS(MAX_HOSTS), .MAX_TASKS(MAX_TASKS)) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.rsp           (rsp),
		.task_total    (task_total_q),
		.host_total    (host_total_q),
		.dist_mode     (dist_mode_q),
		.hm_ctl        (hm_ctl),
		.hm_rd_addr    (hm_rd_addr),
		.hm_wr_addr    (hm_wr_addr),
		.hm_cpu_wdata  (hm_cpu_wdata),
		.hm_cnt_wdata  (hm_cnt_wdata),
		.hm_cpu_rdata  (hm_cpu_rdata),
		.hm_cnt_rdata  (hm_cnt_rdata),
		.tm_ctl        (tm_ctl),
		.tm_rd_addr    (tm_rd_addr),
		.tm_wr_addr    (tm_wr_addr),
		.tm_host_wdata (tm_host_wdata),
		.tm_rank_wdata (tm_rank_wdata),
		.tm_host_rdata (tm_host_rdata),
		.tm_rank_rdata (tm_rank_rdata),
		.stat          (stat)
	);

	// host_cpus / host_tasks
	ttl_host_mem #(.MAX_HOSTS(MAX_HOSTS), .MAX_TASKS(MAX_TASKS)) u_host_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (hm_ctl),
		.rd_addr   (hm_rd_addr),
		.wr_addr   (hm_wr_addr),
		.cpu_wdata (hm_cpu_wdata),
		.cnt_wdata (hm_cnt_wdata),
		.cpu_rdata (hm_cpu_rdata),
		.cnt_rdata (hm_cnt_rdata)
	);

	// task_host / task_rank
	ttl_task_mem #(.MAX_HOSTS(MAX_HOSTS), .MAX_TASKS(MAX_TASKS)) u_task_mem (
		.clk        (clk),
		.ctl        (tm_ctl),
		.rd_addr    (tm_rd_addr),
		.wr_addr    (tm_wr_addr),
		.host_wdata (tm_host_wdata),
		.rank_wdata (tm_rank_wdata),
		.host_rdata (tm_host_rdata),
		.rank_rdata (tm_rank_rdata)
	);

	// one request in flight: after a transfer the request side is closed
	`TTL_ASSERT_NEXT(a_busy_after_req, clk, arst_n, req.valid && req.ready, !req.ready)
	// a result only appears out of the result state
	`TTL_ASSERT(a_rsp_from_resp, clk, arst_n, $rose(rsp.valid) |-> $past(stat.resp_wait))
	// a finished layout is dropped only by a load transfer
	`TTL_ASSERT(a_layout_drop, clk, arst_n, $fell(stat.layout_done) |-> $past(load_xfer))
endmodule

// ===== dv/ttl_layout_checker.sv =====
// Checker for the task-to-host layout block: watches the request, result and register
// channels, predicts each result, compares. Depends on ttl_pkg and the channel interfaces.
`timescale 1ns / 100ps

module ttl_layout_checker (
	input  logic clk,
	input  logic arst_n,
	ttl_in_if    req,
	ttl_out_if   rsp,
	ttl_cfg_if   cfg,
	output int   fail_count,
	output int   pending,
	output int   checked
);
	import ttl_pkg::*;

	localparam int HOSTS = MAX_HOSTS_DEF;
	localparam int TASKS = MAX_TASKS_DEF;

	typedef struct {
		bit              status;
		bit [HOT_W-1:0]  host_of_task;
		bit [RANK_W-1:0] rank_on_host;
		bit [CNT_W-1:0]  host_task_count;
		bit [CPUS_W-1:0] host_cpu_count;
	} placement_answer_t;

	placement_answer_t answer_q[$];

	// register copies
	bit [TT_W-1:0] task_total;
	bit [HT_W-1:0] host_total;
	bit            cyclic;

	// mirror of the block state
	int cpus_of_host[HOSTS];
	int tasks_on_host[HOSTS];
	int host_of[TASKS];
	int rank_of[TASKS];
	int hosts_in_set;
	bit layout_valid;
	int laid_tasks;
	int laid_hosts;

	assign pending = answer_q.size();

	task automatic flag_mismatch(string what, int got, int want);
		$display("[%0t] MISMATCH %s: got %0d, want %0d", $time, what, got, want);
		fail_count++;
	endtask

	function automatic void spread_tasks();
		int nt, nh, placed, rnd, h, k, id;
		bit over, spare;
		nt = (task_total < TASKS) ? task_total : TASKS;
		nh = (host_total < nt) ? host_total : nt;
		if (nh > HOSTS)
			nh = HOSTS;
		foreach (tasks_on_host[i])
			tasks_on_host[i] = 0;
		layout_valid = 1;
		laid_hosts = nh;
		laid_tasks = (nh == 0) ? 0 : nt;
		if (nh == 0)
			return;
		placed = 0;
		over = 0;
		for (rnd = 0; placed < nt; rnd++) begin
			spare = 0;
			for (h = 0; h < nh && placed < nt; h++) begin
				if (rnd < cpus_of_host[h] || over) begin
					if (cyclic) begin
						host_of[placed] = h;
						rank_of[placed] = tasks_on_host[h];
					end
					placed++;
					tasks_on_host[h]++;
					if (rnd + 1 < cpus_of_host[h])
						spare = 1;
				end
			end
			if (!spare)
				over = 1;
		end
		if (!cyclic) begin
			id = 0;
			for (h = 0; h < nh; h++)
				for (k = 0; k < tasks_on_host[h] && id < TASKS; k++) begin
					host_of[id] = h;
					rank_of[id] = k;
					id++;
				end
		end
	endfunction

	function automatic placement_answer_t predict(logic [FUNC_W-1:0] f, int cpus, int rep,
		int tidx, int hsel);
		placement_answer_t a;
		a = '{default: 0};
		case (f)
			FUNC_LOAD: begin
				if (layout_valid) begin
					foreach (tasks_on_host[i])
						tasks_on_host[i] = 0;
					hosts_in_set = 0;
					layout_valid = 0;
				end
				if (rep == 0)
					rep = 1;
				repeat (rep) begin
					if (hosts_in_set < HOSTS)
						cpus_of_host[hosts_in_set++] = cpus;
					else
						a.status = 1;
				end
			end
			FUNC_QTASK: begin
				if (!layout_valid)
					spread_tasks();
				if (tidx < laid_tasks) begin
					a.host_of_task = host_of[tidx];
					a.rank_on_host = rank_of[tidx];
				end else
					a.status = 1;
			end
			FUNC_QHOST: begin
				if (!layout_valid)
					spread_tasks();
				if (hsel < laid_hosts) begin
					a.host_task_count = tasks_on_host[hsel];
					a.host_cpu_count = cpus_of_host[hsel];
				end else
					a.status = 1;
			end
			default: a.status = 1;
		endcase
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		placement_answer_t want;
		if (!arst_n) begin
			task_total <= 1;
			host_total <= 1;
			cyclic <= 0;
			hosts_in_set = 0;
			layout_valid = 0;
			laid_tasks = 0;
			laid_hosts = 0;
			foreach (tasks_on_host[i])
				tasks_on_host[i] = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_TASK_TOTAL: task_total <= cfg.data[TT_W-1:0];
					CFG_HOST_TOTAL: host_total <= cfg.data[HT_W-1:0];
					CFG_DIST_MODE:  cyclic <= cfg.data[0];
					default: ;
				endcase
			end
			if (req.valid && req.ready)
				answer_q.push_back(predict(req.func, req.group_cpus, req.group_repeat,
					req.task_index, req.host_select));
			if (rsp.valid && rsp.ready) begin
				if (answer_q.size() == 0) begin
					flag_mismatch("results with no request outstanding", 1, 0);
				end else begin
					want = answer_q.pop_front();
					checked++;
					if (rsp.status !== want.status)
						flag_mismatch("status", rsp.status, want.status);
					if (rsp.host_of_task !== want.host_of_task)
						flag_mismatch("host_of_task", rsp.host_of_task, want.host_of_task);
					if (rsp.rank_on_host !== want.rank_on_host)
						flag_mismatch("rank_on_host", rsp.rank_on_host, want.rank_on_host);
					if (rsp.host_task_count !== want.host_task_count)
						flag_mismatch("host_task_count", rsp.host_task_count,
							want.host_task_count);
					if (rsp.host_cpu_count !== want.host_cpu_count)
						flag_mismatch("host_cpu_count", rsp.host_cpu_count,
							want.host_cpu_count);
				end
			end
		end
	end

	initial begin
		fail_count = 0;
		checked = 0;
	end

endmodule

// ===== dv/tb_task_to_host_layout.sv =====
// Testbench top for task_to_host_layout: clock, reset, stimulus and verdict.
// Depends on ttl_pkg, the channel interfaces, ttl_layout_checker and the block.
`timescale 1ns / 100ps

module tb_task_to_host_layout;
	import ttl_pkg::*;

	// func code the block must reject
	localparam logic [FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;
	localparam int TARGET_ITEMS = 1300;

	logic clk;
	logic arst_n;

	ttl_in_if  req ();
	ttl_out_if rsp ();
	ttl_cfg_if cfg ();

	int fail_count;
	int pending;
	int checked;

	task_to_host_layout DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	ttl_layout_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.cfg        (cfg),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// hard stop: far above the slowest legal run (a few full-size layout walks)
	initial begin
		#36_000_000;
		$display("Verification failed");
		$finish;
	end

	// ---------------------------------------------------------------
	// Result side back-pressure: the stall style is redrawn, whenever
	// style_age wraps, from always ready, coin flip, and long stalls.
	// ---------------------------------------------------------------
	int stall_style;
	int style_age;
	int stall_run;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 0;
			stall_style <= 0;
			style_age <= 0;
			stall_run <= 0;
		end else begin
			style_age <= (style_age == 149) ? 0 : style_age + 1;
			if (style_age == 149)
				stall_style <= $urandom_range(0, 2);
			case (stall_style)
				0: rsp.ready <= 1;
				1: rsp.ready <= $urandom_range(0, 1);
				default: begin
					if (stall_run > 0) begin
						stall_run <= stall_run - 1;
						rsp.ready <= 0;
					end else begin
						rsp.ready <= 1;
						if ($urandom_range(0, 3) == 0)
							stall_run <= $urandom_range(1, 25);
					end
				end
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Request side: bursts of random length with random gaps between them.
	// valid stays up between transfers inside a burst.
	// ---------------------------------------------------------------
	int burst_left;
	int items_sent;
	int settings_run;
	int hosts_ever_written;	// host_cpus entries with a defined value

	task automatic send_req(logic [FUNC_W-1:0] f, int cpus, int rep, int tidx, int hsel);
		if (burst_left == 0) begin
			req.valid <= 0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 10);
		end
		req.valid <= 1;
		req.func <= f;
		req.group_cpus <= cpus;
		req.group_repeat <= rep;
		req.task_index <= tidx;
		req.host_select <= hsel;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		burst_left--;
		items_sent++;
	endtask

	// drop valid and let every outstanding result come back
	task automatic drain();
		req.valid <= 0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_reg(ttl_cfg_idx_t idx, int val);
		cfg.valid <= 1;
		cfg.index <= idx;
		cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 0;
		@(posedge clk);
	endtask

	task automatic apply_setting(int tt, int ht, int dm);
		set_reg(CFG_TASK_TOTAL, tt);
		set_reg(CFG_HOST_TOTAL, ht);
		set_reg(CFG_DIST_MODE, dm);
		settings_run++;
	endtask

	function automatic int pick_cpus(bit big_job);
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return $urandom_range(0, 4);
		if (r < 9 || big_job)
			return $urandom_range(5, 40);
		return $urandom_range(41, 1023);
	endfunction

	// Load groups covering at least the hosts the layout will read. Where older
	// entries already cover them, a short load leaves the rest from the last set.
	task automatic load_set(int nh, bit big_job);
		int goal, done, rep, cpus;
		goal = nh;
		if (hosts_ever_written >= nh && nh > 0 && $urandom_range(0, 3) == 0)
			goal = $urandom_range(1, nh);
		if (goal == 0)
			goal = 1;
		if ($urandom_range(0, 9) == 0)
			goal = $urandom_range(65, 140);	// spill past the table
		done = 0;
		while (done < goal) begin
			rep = $urandom_range(1, 8);
			if (goal > 64 && $urandom_range(0, 1))
				rep = $urandom_range(9, 127);
			cpus = pick_cpus(big_job);
			if ($urandom_range(0, 7) == 0) begin
				send_req(FUNC_LOAD, cpus, 0, $urandom, $urandom);	// zero repeat = one host
				done++;
			end else begin
				send_req(FUNC_LOAD, cpus, rep, $urandom, $urandom);
				done += rep;
			end
		end
		if (done > hosts_ever_written)
			hosts_ever_written = (done > 64) ? 64 : done;
	endtask

	task automatic query_mix(int n, int tt, int nh);
		int r;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 44)
				send_req(FUNC_QTASK, $urandom, $urandom,
					($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
					: $urandom_range(0, (tt > 1024 ? 1024 : tt) - 1), $urandom);
			else if (r < 88)
				send_req(FUNC_QHOST, $urandom, $urandom, $urandom,
					($urandom_range(0, 9) == 0 || nh == 0) ? $urandom_range(0, 63)
					: $urandom_range(0, nh - 1));
			else if (r < 94)
				send_req(FUNC_UNKNOWN, $urandom, $urandom, $urandom, $urandom);
			else begin
				// new set in mid stream; entries past it keep older values
				send_req(FUNC_LOAD, pick_cpus(1), $urandom_range(1, 4), $urandom, $urandom);
			end
		end
	endtask

	function automatic int min3(int a, int b, int c);
		int m;
		m = (a < b) ? a : b;
		m = (m < c) ? m : c;
		return m;
	endfunction

	initial begin : stimulus
		int tt, ht, dm, nh;
		bit big_job;
		req.valid <= 0;
		req.func <= FUNC_LOAD;
		req.group_cpus <= 0;
		req.group_repeat <= 0;
		req.task_index <= 0;
		req.host_select <= 0;
		cfg.valid <= 0;
		cfg.index <= CFG_TASK_TOTAL;
		cfg.data <= 0;
		arst_n = 0;
		burst_left = 0;
		items_sent = 0;
		settings_run = 0;
		hosts_ever_written = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		repeat (3) @(posedge clk);

		// --- directed: cyclic, 6 tasks on 5 hosts; cpus 1023,0,0,3,3
		apply_setting(6, 5, 1);
		send_req(FUNC_LOAD, 1023, 0, 0, 0);	// zero repeat
		send_req(FUNC_LOAD, 0, 2, 0, 0);
		send_req(FUNC_LOAD, 3, 64, 0, 0);	// table full -> status 1
		hosts_ever_written = 64;
		send_req(FUNC_QTASK, 0, 0, 0, 0);
		send_req(FUNC_QTASK, 0, 0, 5, 0);
		send_req(FUNC_QTASK, 0, 0, 6, 0);	// out of range
		send_req(FUNC_QTASK, 0, 0, 1023, 0);
		send_req(FUNC_QHOST, 0, 0, 0, 0);
		send_req(FUNC_QHOST, 0, 0, 0, 4);
		send_req(FUNC_QHOST, 0, 0, 0, 5);	// out of range
		send_req(FUNC_QHOST, 0, 0, 0, 63);
		send_req(FUNC_UNKNOWN, 1023, 127, 1023, 63);
		drain();
		// stale settings: layout stays until the next load
		apply_setting(1024, 127, 0);
		send_req(FUNC_QTASK, 0, 0, 5, 0);
		send_req(FUNC_QTASK, 0, 0, 6, 0);
		send_req(FUNC_QHOST, 0, 0, 0, 4);
		// full size, block mode, every host at max cpus
		send_req(FUNC_LOAD, 1023, 127, 0, 0);
		send_req(FUNC_QTASK, 0, 0, 1023, 0);
		send_req(FUNC_QHOST, 0, 0, 0, 63);
		drain();
		// no hosts: every query rejected
		apply_setting(2047, 0, 1);
		send_req(FUNC_LOAD, 5, 1, 0, 0);
		send_req(FUNC_QTASK, 0, 0, 0, 0);
		send_req(FUNC_QHOST, 0, 0, 0, 0);
		drain();

		// --- random phases: new setting, load a set, query it; sometimes a
		// stale-setting phase follows with queries only
		while (items_sent < TARGET_ITEMS) begin
			big_job = ($urandom_range(0, 11) == 0);
			tt = big_job ? $urandom_range(97, 1024) : $urandom_range(1, 96);
			ht = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 70);
			dm = $urandom_range(0, 1);
			nh = min3(tt, ht, 64);
			apply_setting(tt, ht, dm);
			load_set(nh, big_job);
			query_mix($urandom_range(8, 30), tt, nh);
			drain();
			if ($urandom_range(0, 4) == 0) begin
				apply_setting($urandom_range(1, 2047), $urandom_range(0, 127),
					$urandom_range(0, 1));
				query_mix($urandom_range(3, 10), tt, nh);
				drain();
			end
		end

		// end: bounded wait for any leftover result
		repeat (200_000) begin
			if (pending == 0)
				break;
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		$display("Summary: %0d requests sent under %0d register settings, %0d results compared",
			items_sent, settings_run, checked);
		$display("Summary: %0d mismatches, %0d results still outstanding", fail_count, pending);
		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
